// ===== hw/rtl/cpd_pkg.sv =====
// shared types and codes for the checksummed packet deframer
package cpd_pkg;

    // deframer phase, one-hot
    typedef enum logic [3:0] {
        ST_HUNT1   = 4'b0001,
        ST_HUNT2   = 4'b0010,
        ST_HEADER  = 4'b0100,
        ST_PAYLOAD = 4'b1000
    } state_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_NODE_ID     = 2'd2,
        CFG_BCAST_ADDR  = 2'd3
    } cfg_index_t;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // end of frame status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_LEN = 2'd2;

    // header byte positions
    localparam logic [7:0] HDR_DEST_START = 8'd4;
    localparam logic [7:0] HDR_NUM_START  = 8'd8;
    localparam logic [7:0] HDR_SUM_START  = 8'd12;
    localparam logic [7:0] HDR_LEN_POS    = 8'd14;

    localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/checksummed_packet_deframer.sv =====
// checksummed packet deframer top level
//
// Usage: one received byte enters per item on the input channel
// (in_valid/in_ready, rx_byte). The block hunts for the two-byte start
// marker, gathers the little-endian header (origin, destination, packet
// number, checksum, length) and then passes each payload byte out as a
// result item. The last payload byte comes out as an end of frame item
// carrying status, header fields and the address flags. A zero length
// byte gives an end of frame item with zero length status at once.
// Timing: a result appears on the output channel in the cycle after
// the byte that causes it is accepted. One byte per cycle is taken
// unless a result waits unaccepted; all work for a byte lies between
// the state registers and the result register, and the widest path
// is the four-operand 16-bit header sum on the length byte.
// Reset: clears the phase, the counter, the output valid and loads the
// configuration reset values (broadcast address all ones).
// Stall: while a result waits unaccepted, in_ready is low; it rises
// again in the cycle the receiver takes the result.
// Configuration: cfg_we with cfg_index and cfg_data writes a register,
// meant to be used while the block is idle.
module checksummed_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  byte_index,
    output logic [1:0]  status,
    output logic [31:0] frame_origin,
    output logic [31:0] frame_dest,
    output logic [31:0] frame_number,
    output logic [7:0]  payload_length,
    output logic        addressed_to_us,
    output logic        is_broadcast,
    output logic        from_self,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [31:0] node_id_reg;
    logic [31:0] bcast_reg;

    // frame state
    cpd_pkg::state_t state_reg, state_next;
    logic [7:0]  field_count_reg, field_count_next;
    logic [31:0] origin_reg, origin_next;
    logic [31:0] dest_reg, dest_next;
    logic [31:0] number_reg, number_next;
    logic [15:0] rx_sum_reg, rx_sum_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] run_sum_reg, run_sum_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [7:0]  index_reg, index_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] origin_out_reg, origin_out_next;
    logic [31:0] dest_out_reg, dest_out_next;
    logic [31:0] number_out_reg, number_out_next;
    logic [7:0]  length_out_reg, length_out_next;
    logic        to_us_reg, to_us_next;
    logic        bcast_out_reg, bcast_out_next;
    logic        self_reg, self_next;

    logic        in_fire;
    logic        last_byte;
    logic [15:0] sum_with_byte;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign sum_with_byte = run_sum_reg + {8'd0, rx_byte};
    assign last_byte = ({1'b0, field_count_reg} + 9'd1) >= {1'b0, length_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= 8'd0;
            sync_second_reg <= 8'd0;
            node_id_reg     <= 32'd0;
            bcast_reg       <= cpd_pkg::BCAST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cpd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                cpd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                cpd_pkg::CFG_NODE_ID:     node_id_reg     <= cfg_data;
                cpd_pkg::CFG_BCAST_ADDR:  bcast_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte deframing and result build
    always_comb
    begin
        state_next       = state_reg;
        field_count_next = field_count_reg;
        origin_next      = origin_reg;
        dest_next        = dest_reg;
        number_next      = number_reg;
        rx_sum_next      = rx_sum_reg;
        length_next      = length_reg;
        run_sum_next     = run_sum_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        pbyte_next       = pbyte_reg;
        index_next       = index_reg;
        status_next      = status_reg;
        origin_out_next  = origin_out_reg;
        dest_out_next    = dest_out_reg;
        number_out_next  = number_out_reg;
        length_out_next  = length_out_reg;
        to_us_next       = to_us_reg;
        bcast_out_next   = bcast_out_reg;
        self_next        = self_reg;

        if (in_fire)
        begin
            case (state_reg)
                cpd_pkg::ST_HUNT1:
                begin
                    if (rx_byte == sync_first_reg)
                        state_next = cpd_pkg::ST_HUNT2;
                end
                cpd_pkg::ST_HUNT2:
                begin
                    if (rx_byte == sync_second_reg)
                    begin
                        state_next       = cpd_pkg::ST_HEADER;
                        field_count_next = 8'd0;
                    end
                    else if (rx_byte != sync_first_reg)
                    begin
                        state_next = cpd_pkg::ST_HUNT1;
                    end
                end
                cpd_pkg::ST_HEADER:
                begin
                    field_count_next = field_count_reg + 8'd1;
                    if (field_count_reg < cpd_pkg::HDR_DEST_START)
                        origin_next = {rx_byte, origin_reg[31:8]};
                    else if (field_count_reg < cpd_pkg::HDR_NUM_START)
                        dest_next = {rx_byte, dest_reg[31:8]};
                    else if (field_count_reg < cpd_pkg::HDR_SUM_START)
                        number_next = {rx_byte, number_reg[31:8]};
                    else if (field_count_reg < cpd_pkg::HDR_LEN_POS)
                        rx_sum_next = {rx_byte, rx_sum_reg[15:8]};
                    else
                    begin
                        // length byte: seed the sum with the header words
                        length_next      = rx_byte;
                        run_sum_next     = origin_reg[15:0] + dest_reg[15:0]
                                         + number_reg[15:0] + {8'd0, rx_byte};
                        field_count_next = 8'd0;
                        if (rx_byte == 8'd0)
                        begin
                            state_next      = cpd_pkg::ST_HUNT1;
                            out_valid_next  = 1'b1;
                            kind_next       = cpd_pkg::KIND_END;
                            pbyte_next      = 8'd0;
                            index_next      = 8'd0;
                            status_next     = cpd_pkg::STATUS_ZERO_LEN;
                            origin_out_next = origin_reg;
                            dest_out_next   = dest_reg;
                            number_out_next = number_reg;
                            length_out_next = 8'd0;
                            to_us_next      = dest_reg == node_id_reg;
                            bcast_out_next  = dest_reg == bcast_reg;
                            self_next       = origin_reg == node_id_reg;
                        end
                        else
                        begin
                            state_next = cpd_pkg::ST_PAYLOAD;
                        end
                    end
                end
                cpd_pkg::ST_PAYLOAD:
                begin
                    run_sum_next   = sum_with_byte;
                    out_valid_next = 1'b1;
                    pbyte_next     = rx_byte;
                    index_next     = field_count_reg;
                    if (last_byte)
                    begin
                        state_next       = cpd_pkg::ST_HUNT1;
                        field_count_next = 8'd0;
                        kind_next        = cpd_pkg::KIND_END;
                        status_next      = (sum_with_byte == rx_sum_reg) ?
                                           cpd_pkg::STATUS_OK : cpd_pkg::STATUS_BAD_SUM;
                        origin_out_next  = origin_reg;
                        dest_out_next    = dest_reg;
                        number_out_next  = number_reg;
                        length_out_next  = length_reg;
                        to_us_next       = dest_reg == node_id_reg;
                        bcast_out_next   = dest_reg == bcast_reg;
                        self_next        = origin_reg == node_id_reg;
                    end
                    else
                    begin
                        field_count_next = field_count_reg + 8'd1;
                        kind_next        = cpd_pkg::KIND_PAYLOAD;
                        status_next      = cpd_pkg::STATUS_OK;
                        origin_out_next  = 32'd0;
                        dest_out_next    = 32'd0;
                        number_out_next  = 32'd0;
                        length_out_next  = 8'd0;
                        to_us_next       = 1'b0;
                        bcast_out_next   = 1'b0;
                        self_next        = 1'b0;
                    end
                end
                default:
                begin
                    state_next = cpd_pkg::ST_HUNT1;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cpd_pkg::ST_HUNT1;
            field_count_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            field_count_reg <= field_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // header and result data
    always_ff @(posedge clk)
    begin
        origin_reg     <= origin_next;
        dest_reg       <= dest_next;
        number_reg     <= number_next;
        rx_sum_reg     <= rx_sum_next;
        length_reg     <= length_next;
        run_sum_reg    <= run_sum_next;
        kind_reg       <= kind_next;
        pbyte_reg      <= pbyte_next;
        index_reg      <= index_next;
        status_reg     <= status_next;
        origin_out_reg <= origin_out_next;
        dest_out_reg   <= dest_out_next;
        number_out_reg <= number_out_next;
        length_out_reg <= length_out_next;
        to_us_reg      <= to_us_next;
        bcast_out_reg  <= bcast_out_next;
        self_reg       <= self_next;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign payload_byte    = pbyte_reg;
    assign byte_index      = index_reg;
    assign status          = status_reg;
    assign frame_origin    = origin_out_reg;
    assign frame_dest      = dest_out_reg;
    assign frame_number    = number_out_reg;
    assign payload_length  = length_out_reg;
    assign addressed_to_us = to_us_reg;
    assign is_broadcast    = bcast_out_reg;
    assign from_self       = self_reg;

    // payload items carry no status or header
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cpd_pkg::KIND_PAYLOAD |->
            status == cpd_pkg::STATUS_OK && frame_dest == 32'd0 &&
            !addressed_to_us && !is_broadcast && !from_self)
        else $error("payload item with header data");

    // payload counter never reaches the length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cpd_pkg::ST_PAYLOAD |-> field_count_reg < length_reg)
        else $error("payload counter past frame length");

    // zero length status only with a zero length byte
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cpd_pkg::KIND_END &&
        status == cpd_pkg::STATUS_ZERO_LEN |-> payload_length == 8'd0)
        else $error("zero length status with nonzero length");

    // a byte taken while hunting for the first marker byte makes no result
    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && state_reg == cpd_pkg::ST_HUNT1 |=> !out_valid)
        else $error("result while hunting for marker");

endmodule

// ===== dv/cpd_frame_checker.sv =====
// result checker for the checksummed packet deframer: predicts from accepted bytes and compares
module cpd_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [7:0]  payload_byte,
    input  logic [7:0]  byte_index,
    input  logic [1:0]  status,
    input  logic [31:0] frame_origin,
    input  logic [31:0] frame_dest,
    input  logic [31:0] frame_number,
    input  logic [7:0]  payload_length,
    input  logic        addressed_to_us,
    input  logic        is_broadcast,
    input  logic        from_self,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          results_owed
);

    // one result item as the deframer should produce it
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  position;
        logic [1:0]  status;
        logic [31:0] origin;
        logic [31:0] dest;
        logic [31:0] number;
        logic [7:0]  length;
        logic        to_us;
        logic        bcast;
        logic        from_us;
    } frame_result_t;

    frame_result_t expected_results[$];

    // shadow of the configuration registers
    logic [7:0]  marker_first;
    logic [7:0]  marker_second;
    logic [31:0] own_id;
    logic [31:0] bcast_id;

    // shadow of the deframer state
    cpd_pkg::state_t hunt_phase;
    logic [7:0]  byte_count;
    logic [31:0] hdr_origin;
    logic [31:0] hdr_dest;
    logic [31:0] hdr_number;
    logic [15:0] hdr_sum;
    logic [7:0]  hdr_length;
    logic [15:0] sum_acc;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: deframer %s mismatch: expected %0h, got %0h",
                 $time, what, want, got);
        mismatch_count++;
    endtask

    // end of frame item, flags taken from the registers as they are now
    task automatic push_frame_end(input logic [1:0] st, input logic [7:0] b,
                                  input logic [7:0] pos);
        frame_result_t r;
        r = '0;
        r.kind      = cpd_pkg::KIND_END;
        r.data_byte = b;
        r.position  = pos;
        r.status    = st;
        r.origin    = hdr_origin;
        r.dest      = hdr_dest;
        r.number    = hdr_number;
        r.length    = hdr_length;
        r.to_us     = (hdr_dest == own_id);
        r.bcast     = (hdr_dest == bcast_id);
        r.from_us   = (hdr_origin == own_id);
        expected_results.push_back(r);
    endtask

    // advance the shadow deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        frame_result_t r;
        r = '0;
        case (hunt_phase)
            cpd_pkg::ST_HUNT1:
            begin
                if (b == marker_first)
                    hunt_phase = cpd_pkg::ST_HUNT2;
            end
            cpd_pkg::ST_HUNT2:
            begin
                if (b == marker_second)
                begin
                    hunt_phase = cpd_pkg::ST_HEADER;
                    byte_count = 8'd0;
                end
                else if (b != marker_first)
                    hunt_phase = cpd_pkg::ST_HUNT1;
            end
            cpd_pkg::ST_HEADER:
            begin
                if (byte_count < cpd_pkg::HDR_LEN_POS)
                begin
                    // little-endian fields shift in from the top
                    if (byte_count < cpd_pkg::HDR_DEST_START)
                        hdr_origin = {b, hdr_origin[31:8]};
                    else if (byte_count < cpd_pkg::HDR_NUM_START)
                        hdr_dest = {b, hdr_dest[31:8]};
                    else if (byte_count < cpd_pkg::HDR_SUM_START)
                        hdr_number = {b, hdr_number[31:8]};
                    else
                        hdr_sum = {b, hdr_sum[15:8]};
                    byte_count = byte_count + 8'd1;
                end
                else
                begin
                    hdr_length = b;
                    sum_acc = hdr_origin[15:0] + hdr_dest[15:0] + hdr_number[15:0]
                              + {8'h00, b};
                    byte_count = 8'd0;
                    if (b == 8'd0)
                    begin
                        hunt_phase = cpd_pkg::ST_HUNT1;
                        push_frame_end(cpd_pkg::STATUS_ZERO_LEN, 8'd0, 8'd0);
                    end
                    else
                        hunt_phase = cpd_pkg::ST_PAYLOAD;
                end
            end
            default:
            begin
                sum_acc = sum_acc + {8'h00, b};
                if ({1'b0, byte_count} + 9'd1 >= {1'b0, hdr_length})
                begin
                    push_frame_end((sum_acc == hdr_sum) ?
                                   cpd_pkg::STATUS_OK : cpd_pkg::STATUS_BAD_SUM,
                                   b, byte_count);
                    hunt_phase = cpd_pkg::ST_HUNT1;
                    byte_count = 8'd0;
                end
                else
                begin
                    r.kind      = cpd_pkg::KIND_PAYLOAD;
                    r.data_byte = b;
                    r.position  = byte_count;
                    expected_results.push_back(r);
                    byte_count = byte_count + 8'd1;
                end
            end
        endcase
    endtask

    // compare one accepted result item with the oldest expectation
    task automatic check_result();
        frame_result_t want;
        if (expected_results.size() == 0)
            report_mismatch("unexpected result", 32'd0, {31'd0, kind});
        else
        begin
            want = expected_results.pop_front();
            if (kind !== want.kind)
                report_mismatch("kind", 32'(want.kind), 32'(kind));
            if (payload_byte !== want.data_byte)
                report_mismatch("payload_byte", 32'(want.data_byte), 32'(payload_byte));
            if (byte_index !== want.position)
                report_mismatch("byte_index", 32'(want.position), 32'(byte_index));
            if (status !== want.status)
                report_mismatch("status", 32'(want.status), 32'(status));
            if (frame_origin !== want.origin)
                report_mismatch("frame_origin", want.origin, frame_origin);
            if (frame_dest !== want.dest)
                report_mismatch("frame_dest", want.dest, frame_dest);
            if (frame_number !== want.number)
                report_mismatch("frame_number", want.number, frame_number);
            if (payload_length !== want.length)
                report_mismatch("payload_length", 32'(want.length), 32'(payload_length));
            if (addressed_to_us !== want.to_us)
                report_mismatch("addressed_to_us", 32'(want.to_us), 32'(addressed_to_us));
            if (is_broadcast !== want.bcast)
                report_mismatch("is_broadcast", 32'(want.bcast), 32'(is_broadcast));
            if (from_self !== want.from_us)
                report_mismatch("from_self", 32'(want.from_us), 32'(from_self));
        end
    endtask

    // watch the channels: results first, then config writes, then new bytes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_first   = 8'd0;
            marker_second  = 8'd0;
            own_id         = 32'd0;
            bcast_id       = cpd_pkg::BCAST_RESET;
            hunt_phase     = cpd_pkg::ST_HUNT1;
            byte_count     = 8'd0;
            hdr_origin     = 32'd0;
            hdr_dest       = 32'd0;
            hdr_number     = 32'd0;
            hdr_sum        = 16'd0;
            hdr_length     = 8'd0;
            sum_acc        = 16'd0;
            mismatch_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_we)
            begin
                case (cfg_index)
                    cpd_pkg::CFG_SYNC_FIRST:  marker_first  = cfg_data[7:0];
                    cpd_pkg::CFG_SYNC_SECOND: marker_second = cfg_data[7:0];
                    cpd_pkg::CFG_NODE_ID:     own_id        = cfg_data;
                    cpd_pkg::CFG_BCAST_ADDR:  bcast_id      = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
        end
        results_owed = expected_results.size();
    end

endmodule

// ===== dv/checksummed_packet_deframer_test.sv =====
// testbench top: drives framed byte streams into the deframer and gives the verdict
module checksummed_packet_deframer_test;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [1:0]  status;
    logic [31:0] frame_origin;
    logic [31:0] frame_dest;
    logic [31:0] frame_number;
    logic [7:0]  payload_length;
    logic        addressed_to_us;
    logic        is_broadcast;
    logic        from_self;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = cpd_pkg::CFG_SYNC_FIRST;
    logic [31:0] cfg_data  = 32'd0;

    int mismatch_count;
    int results_owed;

    // settings in force, used to build frames
    logic [7:0]  cur_sync_a = 8'd0;
    logic [7:0]  cur_sync_b = 8'd0;
    logic [31:0] cur_node   = 32'd0;
    logic [31:0] cur_bcast  = cpd_pkg::BCAST_RESET;

    int burst_left   = 0;
    int frame_bytes  = 0;
    int cycle_count  = 0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int recv_mode    = 0;
    int mode_left    = 0;

    checksummed_packet_deframer dut (.*);

    cpd_frame_checker checker_i (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** checksummed_packet_deframer: FAILED **");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                recv_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (recv_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    // offer one byte, in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_le(input logic [31:0] w, input int nbytes);
        int k;
        for (k = 0; k < nbytes; k++)
            send_byte(w[8*k +: 8]);
    endtask

    // full frame with random payload, optionally with a corrupted checksum
    task automatic send_frame(input logic [31:0] org, input logic [31:0] dst,
                              input logic [31:0] num, input logic [7:0] len,
                              input bit bad_sum);
        logic [7:0]  body[$];
        logic [15:0] sum;
        int          k;
        sum = org[15:0] + dst[15:0] + num[15:0] + {8'h00, len};
        for (k = 0; k < len; k++)
        begin
            body.push_back(8'($urandom_range(0, 255)));
            sum = sum + {8'h00, body[k]};
        end
        if (bad_sum)
            sum = sum ^ 16'($urandom_range(1, 65535));
        send_byte(cur_sync_a);
        send_byte(cur_sync_b);
        send_le(org, 4);
        send_le(dst, 4);
        send_le(num, 4);
        send_le({16'h0000, sum}, 2);
        send_byte(len);
        for (k = 0; k < len; k++)
            send_byte(body[k]);
        frame_bytes += 17 + len;
    endtask

    // stop offering and wait until every result is out
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four registers, high bits of the marker writes are junk
    task automatic load_config(input logic [7:0] sa, input logic [7:0] sb,
                               input logic [31:0] nid, input logic [31:0] bc);
        cfg_we    <= 1'b1;
        cfg_index <= cpd_pkg::CFG_SYNC_FIRST;
        cfg_data  <= {24'($urandom()), sa};
        @(posedge clk);
        cfg_index <= cpd_pkg::CFG_SYNC_SECOND;
        cfg_data  <= {24'($urandom()), sb};
        @(posedge clk);
        cfg_index <= cpd_pkg::CFG_NODE_ID;
        cfg_data  <= nid;
        @(posedge clk);
        cfg_index <= cpd_pkg::CFG_BCAST_ADDR;
        cfg_data  <= bc;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sync_a = sa;
        cur_sync_b = sb;
        cur_node   = nid;
        cur_bcast  = bc;
    endtask

    // mostly well-formed frames, some noise and broken starts
    task automatic random_traffic(input int budget);
        int          start;
        int          pick;
        int          k;
        logic [31:0] org;
        logic [31:0] dst;
        logic [7:0]  len;
        start = frame_bytes;
        while (frame_bytes - start < budget)
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            else if (pick == 1)
            begin
                send_byte(cur_sync_a);
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick == 2)
            begin
                // header cut short, the next frame lands inside it
                send_byte(cur_sync_a);
                send_byte(cur_sync_b);
                k = $urandom_range(1, 14);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: dst = cur_node;
                    1: dst = cur_bcast;
                    default: dst = $urandom();
                endcase
                org = ($urandom_range(0, 3) == 0) ? cur_node : $urandom();
                k = $urandom_range(0, 39);
                if (k == 0)
                    len = 8'd255;
                else if (k < 3)
                    len = 8'd0;
                else
                    len = 8'($urandom_range(1, 12));
                send_frame(org, dst, $urandom(), len, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int phase_no;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: both marker bytes zero, node zero
        send_frame(32'h0, 32'h0, 32'h0, 8'd0, 1'b0);
        send_frame(32'h0, cpd_pkg::BCAST_RESET, 32'h1, 8'd1, 1'b0);
        drain_results();

        load_config(8'hA5, 8'h5A, 32'h1234_5678, cpd_pkg::BCAST_RESET);
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b0);
        // repeated first marker byte keeps the hunt armed
        repeat (3) send_byte(8'hA5);
        send_frame(32'h1234_5678, 32'h1234_5678, 32'h0, 8'd3, 1'b1);
        // marker broken after its first byte
        send_byte(8'hA5);
        send_byte(8'h00);
        send_frame(32'h0, 32'h0, 32'h8000_0001, 8'd0, 1'b0);
        drain_results();

        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            case (phase_no)
                0: load_config(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h0);
                1: load_config(8'h00, 8'hFF, $urandom(), $urandom());
                2: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               32'h0, cpd_pkg::BCAST_RESET);
                default: load_config(8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), $urandom(), $urandom());
            endcase
            // receiver holds off while frames keep coming
            if (phase_no == 1)
                hold_request = 1'b1;
            random_traffic(160);
            drain_results();
        end

        if (mismatch_count == 0 && results_owed == 0)
            $display("** checksummed_packet_deframer: PASSED **");
        else
            $display("** checksummed_packet_deframer: FAILED **");
        $finish;
    end

endmodule
